>>> rtl/alpha_bounding_box_trim_defines.svh
// ----------------------------------------------------------------------------
// alpha bounding box trim assertion macros
// shared property shapes for the checker
// ----------------------------------------------------------------------------
`ifndef ALPHA_BOUNDING_BOX_TRIM_DEFINES_SVH
`define ALPHA_BOUNDING_BOX_TRIM_DEFINES_SVH

// same-cycle implication, off during reset
`define ABBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abbt: same-cycle check failed");

// next-cycle implication, off during reset
`define ABBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abbt: next-cycle check failed");

// what must hold in the cycle after reset is seen low
`define ABBT_ASSERT_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("abbt: reset check failed");

`endif

>>> rtl/abbt_pkg.sv
// ----------------------------------------------------------------------------
// abbt_pkg
// shared widths, register indexes and types of the alpha bounding box trim
// ----------------------------------------------------------------------------
package abbt_pkg;

    localparam int FIELD_W         = 13;
    localparam int ALPHA_W         = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int DEFAULT_MAX_DIM = 4096;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NO_TRIM      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_ON    = 3'd3;

    // size register write toward the tracker
    typedef struct packed {
        logic               width_we;
        logic               height_we;
        logic [FIELD_W-1:0] data;
    } dim_wr_t;

    // output shaping mode
    typedef struct packed {
        logic no_trim;
        logic border_on;
    } mode_t;

endpackage

>>> rtl/abbt_tracker.sv
// ----------------------------------------------------------------------------
// abbt_tracker
// raster position counters, size registers and ink extent trackers
// ----------------------------------------------------------------------------
module abbt_tracker #(
    parameter int MAX_DIM = abbt_pkg::DEFAULT_MAX_DIM,
    localparam int CW     = $clog2(MAX_DIM)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  abbt_pkg::dim_wr_t            dim_wr,
    input  logic                         pix_valid,
    input  logic [abbt_pkg::ALPHA_W-1:0] pix_alpha,
    output logic                         done,
    output logic [CW-1:0]                done_left,
    output logic [CW-1:0]                done_right,
    output logic [CW-1:0]                done_top,
    output logic [CW-1:0]                done_bottom,
    output logic [CW-1:0]                width_m1,
    output logic [CW-1:0]                height_m1
);

    logic [CW-1:0] width_m1_reg,   width_m1_next;
    logic [CW-1:0] height_m1_reg,  height_m1_next;
    logic [CW-1:0] col_reg,        col_next;
    logic [CW-1:0] row_reg,        row_next;
    logic [CW-1:0] min_col_reg,    min_col_next;
    logic [CW-1:0] max_col_reg,    max_col_next;
    logic [CW-1:0] first_row_reg,  first_row_next;
    logic [CW-1:0] last_row_reg,   last_row_next;
    logic          top_found_reg,  top_found_next;
    logic          row_ink_reg,    row_ink_next;

    logic [CW-1:0] dim_m1;
    logic [CW-1:0] min_col_upd;
    logic [CW-1:0] max_col_upd;
    logic [CW-1:0] first_row_upd;
    logic [CW-1:0] last_row_upd;
    logic          ink;
    logic          row_ink_upd;
    logic          row_end;
    logic          frame_end;
    logic          row_hit;

    // size minus one, clamped to 1..MAX_DIM
    always_comb
    begin
        if (dim_wr.data == '0)
        begin
            dim_m1 = '0;
        end
        else if (32'(dim_wr.data) > 32'(MAX_DIM))
        begin
            dim_m1 = CW'(MAX_DIM - 1);
        end
        else
        begin
            dim_m1 = CW'(dim_wr.data - abbt_pkg::FIELD_W'(1));
        end
    end

    // trackers after the current pixel
    always_comb
    begin
        ink           = (pix_alpha != '0);
        min_col_upd   = (ink && (col_reg < min_col_reg)) ? col_reg : min_col_reg;
        max_col_upd   = (ink && (col_reg > max_col_reg)) ? col_reg : max_col_reg;
        row_ink_upd   = row_ink_reg | ink;
        row_end       = (col_reg == width_m1_reg);
        frame_end     = row_end && (row_reg == height_m1_reg);
        row_hit       = row_end && row_ink_upd;
        first_row_upd = (row_hit && !top_found_reg) ? row_reg : first_row_reg;
        last_row_upd  = row_hit ? row_reg : last_row_reg;
    end

    always_comb
    begin
        width_m1_next  = width_m1_reg;
        height_m1_next = height_m1_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        min_col_next   = min_col_reg;
        max_col_next   = max_col_reg;
        first_row_next = first_row_reg;
        last_row_next  = last_row_reg;
        top_found_next = top_found_reg;
        row_ink_next   = row_ink_reg;

        if (dim_wr.width_we || dim_wr.height_we)
        begin
            // new size drops the frame in flight
            if (dim_wr.width_we)
            begin
                width_m1_next = dim_m1;
            end
            if (dim_wr.height_we)
            begin
                height_m1_next = dim_m1;
            end
            col_next       = '0;
            row_next       = '0;
            min_col_next   = dim_wr.width_we ? dim_m1 : width_m1_reg;
            max_col_next   = '0;
            first_row_next = dim_wr.height_we ? dim_m1 : height_m1_reg;
            last_row_next  = '0;
            top_found_next = 1'b0;
            row_ink_next   = 1'b0;
        end
        else if (pix_valid)
        begin
            if (frame_end)
            begin
                col_next       = '0;
                row_next       = '0;
                min_col_next   = width_m1_reg;
                max_col_next   = '0;
                first_row_next = height_m1_reg;
                last_row_next  = '0;
                top_found_next = 1'b0;
                row_ink_next   = 1'b0;
            end
            else
            begin
                min_col_next   = min_col_upd;
                max_col_next   = max_col_upd;
                first_row_next = first_row_upd;
                last_row_next  = last_row_upd;
                top_found_next = top_found_reg | row_hit;
                if (row_end)
                begin
                    col_next     = '0;
                    row_next     = row_reg + CW'(1);
                    row_ink_next = 1'b0;
                end
                else
                begin
                    col_next     = col_reg + CW'(1);
                    row_ink_next = row_ink_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_m1_reg  <= '0;
            height_m1_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            min_col_reg   <= '0;
            max_col_reg   <= '0;
            first_row_reg <= '0;
            last_row_reg  <= '0;
            top_found_reg <= 1'b0;
            row_ink_reg   <= 1'b0;
        end
        else
        begin
            width_m1_reg  <= width_m1_next;
            height_m1_reg <= height_m1_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            first_row_reg <= first_row_next;
            last_row_reg  <= last_row_next;
            top_found_reg <= top_found_next;
            row_ink_reg   <= row_ink_next;
        end
    end

    assign done        = pix_valid && frame_end;
    assign done_left   = min_col_upd;
    assign done_right  = max_col_upd;
    assign done_top    = first_row_upd;
    assign done_bottom = last_row_upd;
    assign width_m1    = width_m1_reg;
    assign height_m1   = height_m1_reg;

endmodule

>>> rtl/abbt_finish.sv
// ----------------------------------------------------------------------------
// abbt_finish
// holds the raw extent of a finished frame and shapes it into the result
// ----------------------------------------------------------------------------
module abbt_finish #(
    parameter int MAX_DIM = abbt_pkg::DEFAULT_MAX_DIM,
    localparam int CW     = $clog2(MAX_DIM)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         done,
    input  logic [CW-1:0]                done_left,
    input  logic [CW-1:0]                done_right,
    input  logic [CW-1:0]                done_top,
    input  logic [CW-1:0]                done_bottom,
    input  abbt_pkg::mode_t              mode,
    input  logic [CW-1:0]                width_m1,
    input  logic [CW-1:0]                height_m1,
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [abbt_pkg::FIELD_W-1:0] box_left,
    output logic [abbt_pkg::FIELD_W-1:0] box_top,
    output logic [abbt_pkg::FIELD_W-1:0] box_right,
    output logic [abbt_pkg::FIELD_W-1:0] box_bottom,
    output logic [abbt_pkg::FIELD_W-1:0] box_width,
    output logic [abbt_pkg::FIELD_W-1:0] box_height
);

    localparam int FW = abbt_pkg::FIELD_W;
    localparam int XW = (CW + 1 > FW) ? CW + 1 : FW;

    logic            fin_valid_reg, fin_valid_next;
    logic [CW-1:0]   fin_left_reg;
    logic [CW-1:0]   fin_right_reg;
    logic [CW-1:0]   fin_top_reg;
    logic [CW-1:0]   fin_bottom_reg;
    abbt_pkg::mode_t fin_mode_reg;

    logic            out_valid_reg, out_valid_next;
    logic [FW-1:0]   left_reg, top_reg, right_reg, bottom_reg, width_reg, height_reg;

    logic            advance;
    logic [XW-1:0]   wm1_x, hm1_x;
    logic [XW-1:0]   l_raw, r_raw, t_raw, b_raw;
    logic [XW-1:0]   l_box, r_box, t_box, b_box;
    logic [XW-1:0]   w_box, h_box;

    assign advance = fin_valid_reg && (!out_valid_reg || !out_stall);
    assign busy    = fin_valid_reg && !advance;

    always_comb
    begin
        wm1_x = XW'(width_m1);
        hm1_x = XW'(height_m1);

        if (fin_mode_reg.no_trim)
        begin
            l_raw = '0;
            t_raw = '0;
            r_raw = wm1_x;
            b_raw = hm1_x;
        end
        else
        begin
            // empty frame collapses onto the right column and the top row
            l_raw = XW'(fin_left_reg);
            r_raw = (fin_left_reg > fin_right_reg) ? XW'(fin_left_reg) : XW'(fin_right_reg);
            t_raw = (fin_top_reg > fin_bottom_reg) ? XW'(fin_bottom_reg) : XW'(fin_top_reg);
            b_raw = XW'(fin_bottom_reg);
        end

        // grow by one where the image allows, then shift by one
        if (fin_mode_reg.border_on)
        begin
            l_box = (l_raw == '0) ? XW'(1) : l_raw;
            t_box = (t_raw == '0) ? XW'(1) : t_raw;
            r_box = (r_raw < wm1_x) ? r_raw + XW'(2) : r_raw + XW'(1);
            b_box = (b_raw < hm1_x) ? b_raw + XW'(2) : b_raw + XW'(1);
        end
        else
        begin
            l_box = l_raw;
            t_box = t_raw;
            r_box = r_raw;
            b_box = b_raw;
        end

        w_box = r_box - l_box + XW'(1);
        h_box = b_box - t_box + XW'(1);
    end

    always_comb
    begin
        fin_valid_next = done || (fin_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            fin_left_reg   <= done_left;
            fin_right_reg  <= done_right;
            fin_top_reg    <= done_top;
            fin_bottom_reg <= done_bottom;
            fin_mode_reg   <= mode;
        end
        if (advance)
        begin
            left_reg   <= l_box[FW-1:0];
            top_reg    <= t_box[FW-1:0];
            right_reg  <= r_box[FW-1:0];
            bottom_reg <= b_box[FW-1:0];
            width_reg  <= w_box[FW-1:0];
            height_reg <= h_box[FW-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign box_left   = left_reg;
    assign box_top    = top_reg;
    assign box_right  = right_reg;
    assign box_bottom = bottom_reg;
    assign box_width  = width_reg;
    assign box_height = height_reg;

endmodule

>>> rtl/alpha_bounding_box_trim.sv
// ----------------------------------------------------------------------------
// alpha_bounding_box_trim
// finds the box around the nonzero alpha of a raster frame
// ----------------------------------------------------------------------------
// usage
//   pixel channel: in_valid / in_stall / alpha, one alpha byte per pixel in
//   raster order, frame_width by frame_height pixels per frame
//   result channel: out_valid / out_stall / box_*, one transaction per frame
//   config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, written
//   while the block is idle; index 0 width, 1 height, 2 no trim,
//   3 border on, other indexes ignored; a size write restarts the frame
// throughput: one pixel per cycle while in_stall is low, set by the single tracker update per pixel
// result path: the edge that accepts the last pixel loads the finish register;
//   out_valid rises as the frame moves on from there into the result register
// stall: while the result register is stalled a finished frame waits in the
//   finish register; in_stall is high while the finish register holds a
//   frame that cannot move on, so pixels flow while only one result waits
// reset: size registers 1, no trim 0, border on 1, trackers cleared,
//   no result pending; cfg_ready is always high
// ----------------------------------------------------------------------------
module alpha_bounding_box_trim #(
    parameter int MAX_DIM = abbt_pkg::DEFAULT_MAX_DIM
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // pixel channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [abbt_pkg::ALPHA_W-1:0]   alpha,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [abbt_pkg::FIELD_W-1:0]   box_left,
    output logic [abbt_pkg::FIELD_W-1:0]   box_top,
    output logic [abbt_pkg::FIELD_W-1:0]   box_right,
    output logic [abbt_pkg::FIELD_W-1:0]   box_bottom,
    output logic [abbt_pkg::FIELD_W-1:0]   box_width,
    output logic [abbt_pkg::FIELD_W-1:0]   box_height,
    // config channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [abbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abbt_pkg::FIELD_W-1:0]   cfg_data
);

    localparam int CW = $clog2(MAX_DIM);

    abbt_pkg::mode_t   mode_reg, mode_next;
    abbt_pkg::dim_wr_t dim_wr;

    logic          cfg_we;
    logic          pix_accept;
    logic          busy;
    logic          done;
    logic [CW-1:0] done_left, done_right, done_top, done_bottom;
    logic [CW-1:0] width_m1, height_m1;

    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign in_stall   = busy;
    assign pix_accept = in_valid && !in_stall;

    // register decode
    always_comb
    begin
        mode_next        = mode_reg;
        dim_wr.width_we  = 1'b0;
        dim_wr.height_we = 1'b0;
        dim_wr.data      = cfg_data;
        if (cfg_we)
        begin
            unique case (cfg_index)
                abbt_pkg::REG_FRAME_WIDTH:  dim_wr.width_we    = 1'b1;
                abbt_pkg::REG_FRAME_HEIGHT: dim_wr.height_we   = 1'b1;
                abbt_pkg::REG_NO_TRIM:      mode_next.no_trim   = cfg_data[0];
                abbt_pkg::REG_BORDER_ON:    mode_next.border_on = cfg_data[0];
                default:                    mode_next           = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg.no_trim   <= 1'b0;
            mode_reg.border_on <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // per-pixel extent tracking
    abbt_tracker #(
        .MAX_DIM (MAX_DIM)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .dim_wr      (dim_wr),
        .pix_valid   (pix_accept),
        .pix_alpha   (alpha),
        .done        (done),
        .done_left   (done_left),
        .done_right  (done_right),
        .done_top    (done_top),
        .done_bottom (done_bottom),
        .width_m1    (width_m1),
        .height_m1   (height_m1)
    );

    // box shaping and result register
    abbt_finish #(
        .MAX_DIM (MAX_DIM)
    ) u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .done        (done),
        .done_left   (done_left),
        .done_right  (done_right),
        .done_top    (done_top),
        .done_bottom (done_bottom),
        .mode        (mode_reg),
        .width_m1    (width_m1),
        .height_m1   (height_m1),
        .busy        (busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_right   (box_right),
        .box_bottom  (box_bottom),
        .box_width   (box_width),
        .box_height  (box_height)
    );

endmodule

>>> rtl/abbt_checker.sv
// ----------------------------------------------------------------------------
// abbt_checker
// port-level checks of the alpha bounding box trim, bound to the top level
// ----------------------------------------------------------------------------
`include "alpha_bounding_box_trim_defines.svh"

module abbt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [abbt_pkg::ALPHA_W-1:0]   alpha,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [abbt_pkg::FIELD_W-1:0]   box_left,
    input logic [abbt_pkg::FIELD_W-1:0]   box_top,
    input logic [abbt_pkg::FIELD_W-1:0]   box_right,
    input logic [abbt_pkg::FIELD_W-1:0]   box_bottom,
    input logic [abbt_pkg::FIELD_W-1:0]   box_width,
    input logic [abbt_pkg::FIELD_W-1:0]   box_height
);

    // pixels stall only behind a stalled result
    `ABBT_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // size fields agree with the edges
    `ABBT_ASSERT_IMPLY(a_box_size, clk, rst_n, out_valid,
        (box_width == box_right - box_left + 13'd1) &&
        (box_height == box_bottom - box_top + 13'd1))

    // a stalled result holds
    `ABBT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(box_left) && $stable(box_top) && $stable(box_right) &&
        $stable(box_bottom))

    // a stalled pixel holds
    `ABBT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        in_valid && $stable(alpha))

    // nothing pending out of reset
    `ABBT_ASSERT_RESET(a_reset_idle, clk, rst_n, !out_valid && !in_stall)

endmodule

bind alpha_bounding_box_trim abbt_checker u_abbt_checker (.*);
